>>> src/pilm_pkg.sv
// package: shared types and codes for the priority inheritance lock manager
`default_nettype none
package pilm_pkg;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_LOCK   = 2'd1,
    MODE_UNLOCK = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_NO_MUTEX = 3'd2,
    ST_NOT_OWN  = 3'd3,
    ST_EXISTS   = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  localparam int unsigned ModeW = 2;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned PidW  = 16;
  localparam int unsigned PrioW = 8;
  localparam int unsigned StatW = 3;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  mutex_index;
    logic [PidW-1:0]  process_id;
    logic [PrioW-1:0] request_priority;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [PidW-1:0]  raise_pid;
    logic             raise_valid;
    logic [PrioW-1:0] priority_value;
    logic             priority_valid;
    logic [PidW-1:0]  next_owner_pid;
    logic             next_owner_valid;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;    // capture request, read slot tables
    logic decide;      // run create/lock/unlock decision, issue store access
    logic finish_rw;   // take store read data (unlock hand-over)
    logic q_start;     // query walk: reset slot/k and best
    logic q_issue;     // query walk: issue read for current (slot,k)
    logic q_accum;     // query walk: fold read data
    logic q_adv;       // query walk: advance position
    logic emit;        // place result in output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;   // decision needs a store read
    logic q_valid_pos; // current walk position is a live waiter
    logic q_last;      // walk at final position
  } stat_t;

endpackage
`default_nettype wire

>>> src/pilm_if.sv
// interface: valid/ready channel carrying one item
`default_nettype none
interface pilm_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/pilm_ram.sv
// generic single-port ram with registered read
`default_nettype none
module pilm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> src/pilm_ctrl.sv
// controller: command sequencing state machine
`default_nettype none
module pilm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           out_busy_i,
  input  wire logic [1:0]     mode_i,
  input  wire pilm_pkg::stat_t stat_i,
  output pilm_pkg::cmd_t      cmd_o
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_RDWAIT = 8'b0000_0100,
    S_RDDONE = 8'b0000_1000,
    S_QISSUE = 8'b0001_0000,
    S_QWAIT  = 8'b0010_0000,
    S_QACC   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (mode_i == pilm_pkg::MODE_QUERY) begin
            cmd_o.q_start = 1'b1;
            state_d = S_QISSUE;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = stat_i.need_read ? S_RDWAIT : S_EMIT;
      end
      S_RDWAIT: state_d = S_RDDONE;
      S_RDDONE: begin
        cmd_o.finish_rw = 1'b1;
        state_d = S_EMIT;
      end
      S_QISSUE: begin
        if (stat_i.q_valid_pos) begin
          cmd_o.q_issue = 1'b1;
          state_d = S_QWAIT;
        end else begin
          cmd_o.q_adv = 1'b1;
          state_d = stat_i.q_last ? S_EMIT : S_QISSUE;
        end
      end
      S_QWAIT: begin
        cmd_o.q_issue = 1'b1;
        state_d = S_QACC;
      end
      S_QACC: begin
        cmd_o.q_accum = 1'b1;
        cmd_o.q_adv = 1'b1;
        state_d = stat_i.q_last ? S_EMIT : S_QISSUE;
      end
      S_EMIT: begin
        if (!out_busy_i) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !out_busy_i) else $error("emit into busy output");
  a_rd_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RDWAIT |=> state_q == S_RDDONE) else $error("read wait broken");
`endif
endmodule
`default_nettype wire

>>> src/pilm_dp.sv
// datapath: mutex tables, waiter stores and query walk
`default_nettype none
module pilm_dp #(
  parameter int unsigned MutexSlots = 16,
  parameter int unsigned WaitDepth  = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pilm_pkg::req_t  req_i,
  input  wire pilm_pkg::cmd_t  cmd_i,
  output pilm_pkg::stat_t      stat_o,
  output pilm_pkg::rsp_t       rsp_o
);
  localparam int unsigned SW = (MutexSlots > 1) ? $clog2(MutexSlots) : 1;
  localparam int unsigned KW = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int unsigned CW = $clog2(WaitDepth + 1);
  localparam int unsigned Entries = MutexSlots * WaitDepth;
  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned PidW = pilm_pkg::PidW;
  localparam int unsigned PrioW = pilm_pkg::PrioW;

  logic [MutexSlots-1:0] exists_q, held_q;
  logic [PidW-1:0]       oid_q   [MutexSlots];
  logic [PrioW-1:0]      obase_q [MutexSlots];
  logic [KW-1:0]         head_q  [MutexSlots];
  logic [CW-1:0]         cnt_q   [MutexSlots];

  pilm_pkg::req_t req_q;
  pilm_pkg::rsp_t rsp_q;
  logic [SW-1:0]  s;
  logic           in_range;

  // query walk state
  logic [SW-1:0]  qs_q;
  logic [KW-1:0]  qk_q;
  logic [PrioW:0] best_q;

  // store access
  logic           we;
  logic [AW-1:0]  addr;
  logic [PidW-1:0]  rid;
  logic [PrioW-1:0] rprio;
  logic [SW-1:0]  rd_slot_q;

  assign s        = SW'(req_q.mutex_index);
  assign in_range = ({{(32-pilm_pkg::IdxW){1'b0}}, req_q.mutex_index} < MutexSlots);

  function automatic logic [AW-1:0] pos(input logic [SW-1:0] sl, input logic [KW-1:0] h,
                                        input logic [CW-1:0] k);
    logic [KW-1:0] off;
    logic [CW:0]   sum;
    logic [31:0]   full;
    begin
      sum  = {1'b0, k} + {{(CW+1-KW){1'b0}}, h};
      if (sum >= (CW+1)'(WaitDepth)) sum = sum - (CW+1)'(WaitDepth);
      off  = sum[KW-1:0];
      full = 32'(sl) * 32'(WaitDepth) + ((WaitDepth > 1) ? 32'(off) : 32'd0);
      pos  = full[AW-1:0];
    end
  endfunction

  logic present, holder;
  assign present = in_range && exists_q[s];
  assign holder  = held_q[s] && (oid_q[s] == req_q.process_id);

  logic q_live;
  assign q_live = exists_q[qs_q] && held_q[qs_q] && (oid_q[qs_q] == req_q.process_id)
                  && (CW'(qk_q) < cnt_q[qs_q]);

  assign stat_o.need_read   = (req_q.mode == pilm_pkg::MODE_UNLOCK) && present && holder
                              && (cnt_q[s] != '0);
  assign stat_o.q_valid_pos = q_live;
  assign stat_o.q_last      = (32'(qs_q) == MutexSlots - 1) && (32'(qk_q) == WaitDepth - 1);

  always_comb begin
    we   = 1'b0;
    addr = pos(s, head_q[s], '0);
    if (cmd_i.decide && req_q.mode == pilm_pkg::MODE_LOCK && present && held_q[s]
        && cnt_q[s] < CW'(WaitDepth)) begin
      we   = 1'b1;
      addr = pos(s, head_q[s], cnt_q[s]);
    end else if (cmd_i.q_issue) begin
      addr = pos(qs_q, head_q[qs_q], CW'(qk_q));
    end
  end

  pilm_ram #(.Width(PidW), .Depth(Entries)) u_id_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(req_q.process_id), .rdata_o(rid));
  pilm_ram #(.Width(PrioW), .Depth(Entries)) u_prio_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(req_q.request_priority), .rdata_o(rprio));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.decide) rd_slot_q <= s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q <= '0;
      held_q   <= '0;
      for (int i = 0; i < MutexSlots; i++) begin
        oid_q[i]   <= '0;
        obase_q[i] <= '0;
        head_q[i]  <= '0;
        cnt_q[i]   <= '0;
      end
      qs_q   <= '0;
      qk_q   <= '0;
      best_q <= '0;
      rsp_q  <= '0;
    end else begin
      if (cmd_i.load_req) begin
        rsp_q <= '0;
      end
      if (cmd_i.q_start) begin
        qs_q   <= '0;
        qk_q   <= '0;
        best_q <= {1'b1, {PrioW{1'b0}}};
      end
      if (cmd_i.decide) begin
        unique case (req_q.mode)
          pilm_pkg::MODE_CREATE: begin
            if (!in_range) rsp_q.status <= pilm_pkg::ST_NO_MUTEX;
            else if (exists_q[s]) rsp_q.status <= pilm_pkg::ST_EXISTS;
            else begin
              exists_q[s] <= 1'b1;
              held_q[s]   <= 1'b0;
              oid_q[s]    <= '0;
              obase_q[s]  <= '0;
              head_q[s]   <= '0;
              cnt_q[s]    <= '0;
            end
          end
          pilm_pkg::MODE_LOCK: begin
            if (!present) rsp_q.status <= pilm_pkg::ST_NO_MUTEX;
            else if (!held_q[s]) begin
              held_q[s]  <= 1'b1;
              oid_q[s]   <= req_q.process_id;
              obase_q[s] <= req_q.request_priority;
            end else if (cnt_q[s] >= CW'(WaitDepth)) begin
              rsp_q.status <= pilm_pkg::ST_FULL;
            end else begin
              cnt_q[s]             <= cnt_q[s] + 1'b1;
              rsp_q.status         <= pilm_pkg::ST_QUEUED;
              rsp_q.raise_pid      <= oid_q[s];
              rsp_q.raise_valid    <= 1'b1;
              rsp_q.priority_value <= req_q.request_priority;
              rsp_q.priority_valid <= 1'b1;
            end
          end
          pilm_pkg::MODE_UNLOCK: begin
            if (!present) rsp_q.status <= pilm_pkg::ST_NO_MUTEX;
            else if (!holder) rsp_q.status <= pilm_pkg::ST_NOT_OWN;
            else begin
              rsp_q.priority_value <= obase_q[s];
              rsp_q.priority_valid <= 1'b1;
              if (cnt_q[s] == '0) begin
                held_q[s]  <= 1'b0;
                oid_q[s]   <= '0;
                obase_q[s] <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.finish_rw) begin
        oid_q[rd_slot_q]   <= rid;
        obase_q[rd_slot_q] <= rprio;
        head_q[rd_slot_q]  <= (32'(head_q[rd_slot_q]) == WaitDepth - 1) ? '0
                              : head_q[rd_slot_q] + 1'b1;
        cnt_q[rd_slot_q]   <= cnt_q[rd_slot_q] - 1'b1;
        rsp_q.next_owner_pid   <= rid;
        rsp_q.next_owner_valid <= 1'b1;
      end
      if (cmd_i.q_accum && {1'b0, rprio} < best_q) begin
        best_q <= {1'b0, rprio};
      end
      if (cmd_i.q_adv) begin
        if (32'(qk_q) == WaitDepth - 1) begin
          qk_q <= '0;
          qs_q <= qs_q + 1'b1;
        end else begin
          qk_q <= qk_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_o = rsp_q;
    if (req_q.mode == pilm_pkg::MODE_QUERY) begin
      rsp_o = '0;
      rsp_o.priority_valid = !best_q[PrioW];
      rsp_o.priority_value = best_q[PrioW] ? '0 : best_q[PrioW-1:0];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> cnt_q[s] <= CW'(WaitDepth)) else $error("queue count overflow");
  a_write_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> held_q[s] && exists_q[s]) else $error("waiter write on free mutex");
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_rw |-> cnt_q[rd_slot_q] != '0) else $error("hand-over with empty queue");
`endif
endmodule
`default_nettype wire

>>> src/priority_inheritance_lock_manager_unit.sv
// top level: priority inheritance lock manager
// usage:
//   in_if carries one command item (mode, mutex_index, process_id,
//   request_priority); out_if carries one result item per command.
//   create, lock, error results and an unlock with no waiters pass through
//   the decide and emit states; an unlock that hands the mutex to a waiter
//   goes through decide, read wait, read done and emit (waiter store read).
//   query walks every slot and queue position in turn: a position that is
//   not a live waiter is skipped, and a live waiter is read from the
//   waiter store (issue, wait, accumulate) and folded into the lowest
//   priority value found.
//   one command is in flight at a time; the next item is accepted once
//   the result has been placed in the output register, so a result
//   waiting on a stalled receiver overlaps the next command's work.
//   if the receiver stalls, the result holds and a finished next result
//   waits in the controller until the output register frees.
//   reset clears the mutex tables and queue counts; no clearing pass.
`default_nettype none
module priority_inheritance_lock_manager_unit #(
  parameter int unsigned MUTEX_SLOTS = 16,
  parameter int unsigned WAIT_DEPTH  = 8
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pilm_if.sink     in_if,
  pilm_if.source   out_if
);
  pilm_pkg::cmd_t  cmd;
  pilm_pkg::stat_t stat;
  pilm_pkg::req_t  req;
  pilm_pkg::rsp_t  rsp;
  pilm_pkg::rsp_t  out_q;
  logic            out_valid_q;
  logic            in_ready;

  assign req = pilm_pkg::req_t'(in_if.data);
  assign in_if.ready = in_ready;

  pilm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .out_busy_i (out_valid_q && !out_if.ready),
    .mode_i     (req.mode),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pilm_dp #(.MutexSlots(MUTEX_SLOTS), .WaitDepth(WAIT_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .req_i (req),
    .cmd_i (cmd),
    .stat_o(stat),
    .rsp_o (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) out_q <= rsp;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped under stall");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_ready |=> !in_ready) else $error("second item taken");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_if.valid) else $error("result not shown");
`endif
endmodule
`default_nettype wire

>>> tb/sv/tb_priority_inheritance_lock_manager_unit.sv
// testbench: directed and random command items against a behavioral lock table predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_priority_inheritance_lock_manager_unit;

  localparam int unsigned Slots = 16;
  localparam int unsigned Depth = 8;
  localparam int unsigned PidW  = pilm_pkg::PidW;
  localparam int unsigned PrioW = pilm_pkg::PrioW;
  localparam int unsigned IdxW  = pilm_pkg::IdxW;

  logic clk_i;
  logic rst_ni;

  pilm_if #(.W($bits(pilm_pkg::req_t))) cmd_if ();
  pilm_if #(.W($bits(pilm_pkg::rsp_t))) rsp_if ();

  priority_inheritance_lock_manager_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_if.sink),
    .out_if (rsp_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // lock table copy
  bit             tbl_exists [Slots];
  bit             tbl_held   [Slots];
  bit [PidW-1:0]  tbl_owner  [Slots];
  bit [PrioW-1:0] tbl_base   [Slots];
  bit [PidW-1:0]  tbl_wpid   [Slots][$];
  bit [PrioW-1:0] tbl_wprio  [Slots][$];

  pilm_pkg::rsp_t rsp_expected_q[$];
  int   n_errors;
  int   idle_pct;
  int   rsp_holdoff;
  bit   send_done;

  task automatic report_mismatch(input string what, input pilm_pkg::rsp_t got,
                                 input pilm_pkg::rsp_t want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    n_errors++;
  endtask

  function automatic pilm_pkg::rsp_t predict_command(input pilm_pkg::req_t c);
    pilm_pkg::rsp_t r;
    int s;
    int best;
    r = '0;
    s = c.mutex_index;
    case (pilm_pkg::mode_e'(c.mode))
      pilm_pkg::MODE_CREATE: begin
        if (tbl_exists[s]) begin
          r.status = pilm_pkg::ST_EXISTS;
        end else begin
          tbl_exists[s] = 1'b1;
          tbl_held[s] = 1'b0;
          tbl_owner[s] = '0;
          tbl_base[s] = '0;
          tbl_wpid[s].delete();
          tbl_wprio[s].delete();
        end
      end
      pilm_pkg::MODE_LOCK: begin
        if (!tbl_exists[s]) begin
          r.status = pilm_pkg::ST_NO_MUTEX;
        end else if (!tbl_held[s]) begin
          tbl_held[s] = 1'b1;
          tbl_owner[s] = c.process_id;
          tbl_base[s] = c.request_priority;
        end else if (tbl_wpid[s].size() >= Depth) begin
          r.status = pilm_pkg::ST_FULL;
        end else begin
          tbl_wpid[s].push_back(c.process_id);
          tbl_wprio[s].push_back(c.request_priority);
          r.status = pilm_pkg::ST_QUEUED;
          r.raise_pid = tbl_owner[s];
          r.raise_valid = 1'b1;
          r.priority_value = c.request_priority;
          r.priority_valid = 1'b1;
        end
      end
      pilm_pkg::MODE_UNLOCK: begin
        if (!tbl_exists[s]) begin
          r.status = pilm_pkg::ST_NO_MUTEX;
        end else if (!tbl_held[s] || tbl_owner[s] != c.process_id) begin
          r.status = pilm_pkg::ST_NOT_OWN;
        end else begin
          r.priority_value = tbl_base[s];
          r.priority_valid = 1'b1;
          if (tbl_wpid[s].size() > 0) begin
            tbl_owner[s] = tbl_wpid[s].pop_front();
            tbl_base[s] = tbl_wprio[s].pop_front();
            r.next_owner_pid = tbl_owner[s];
            r.next_owner_valid = 1'b1;
          end else begin
            tbl_held[s] = 1'b0;
            tbl_owner[s] = '0;
            tbl_base[s] = '0;
          end
        end
      end
      default: begin
        best = 256;
        for (int i = 0; i < Slots; i++) begin
          if (tbl_exists[i] && tbl_held[i] && tbl_owner[i] == c.process_id) begin
            foreach (tbl_wprio[i][k]) begin
              if (tbl_wprio[i][k] < best) best = tbl_wprio[i][k];
            end
          end
        end
        if (best < 256) begin
          r.priority_value = best[PrioW-1:0];
          r.priority_valid = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_command(input pilm_pkg::mode_e m, input int idx, input int pid,
                              input int prio);
    pilm_pkg::req_t c;
    c.mode = m;
    c.mutex_index = idx[IdxW-1:0];
    c.process_id = pid[PidW-1:0];
    c.request_priority = prio[PrioW-1:0];
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    rsp_expected_q.push_back(predict_command(c));
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pilm_pkg::rsp_t got;
    pilm_pkg::rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (rsp_expected_q.size() == 0) begin
        report_mismatch("unexpected item", got, '0);
      end else begin
        want = rsp_expected_q.pop_front();
        if (got.status != want.status) report_mismatch("status", got, want);
        if (got.raise_pid != want.raise_pid) report_mismatch("raise_pid", got, want);
        if (got.raise_valid != want.raise_valid) report_mismatch("raise_valid", got, want);
        if (got.priority_value != want.priority_value)
          report_mismatch("priority_value", got, want);
        if (got.priority_valid != want.priority_valid)
          report_mismatch("priority_valid", got, want);
        if (got.next_owner_pid != want.next_owner_pid)
          report_mismatch("next_owner_pid", got, want);
        if (got.next_owner_valid != want.next_owner_valid)
          report_mismatch("next_owner_valid", got, want);
      end
    end
  end

  // receiver readiness, with a counted hold-off
  always @(posedge clk_i) begin
    if (rsp_holdoff > 0) begin
      rsp_holdoff <= rsp_holdoff - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic test_directed();
    send_command(pilm_pkg::MODE_LOCK, 3, 16'h0001, 8'h10);
    send_command(pilm_pkg::MODE_UNLOCK, 3, 16'h0001, 0);
    send_command(pilm_pkg::MODE_CREATE, 0, 0, 0);
    send_command(pilm_pkg::MODE_CREATE, 15, 16'hffff, 8'hff);
    send_command(pilm_pkg::MODE_CREATE, 0, 0, 0);
    send_command(pilm_pkg::MODE_UNLOCK, 0, 0, 0);
    send_command(pilm_pkg::MODE_LOCK, 15, 16'hffff, 8'hff);
    send_command(pilm_pkg::MODE_LOCK, 15, 16'hffff, 8'h00);
    for (int i = 0; i < 8; i++) begin
      send_command(pilm_pkg::MODE_LOCK, 15, 16'h5a5a + i, 8'h80 - i);
    end
    send_command(pilm_pkg::MODE_QUERY, 7, 16'hffff, 0);
    send_command(pilm_pkg::MODE_QUERY, 0, 16'h1234, 0);
    send_command(pilm_pkg::MODE_UNLOCK, 15, 16'h0000, 0);
    send_command(pilm_pkg::MODE_UNLOCK, 15, 16'hffff, 0);
    send_command(pilm_pkg::MODE_LOCK, 15, 16'h0000, 8'h55);
    send_command(pilm_pkg::MODE_LOCK, 0, 16'h0000, 8'haa);
    send_command(pilm_pkg::MODE_UNLOCK, 0, 16'h0000, 0);
    send_command(pilm_pkg::MODE_UNLOCK, 0, 16'h0000, 0);
    send_command(pilm_pkg::MODE_QUERY, 0, 16'h0000, 0);
  endtask

  task automatic test_random(input int n);
    int idx;
    int pick;
    for (int i = 0; i < n; i++) begin
      idx = $urandom_range(99) < 80 ? $urandom_range(5) : $urandom_range(15);
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_command(pilm_pkg::MODE_CREATE, idx, $urandom, $urandom);
      end else if (pick < 50) begin
        send_command(pilm_pkg::MODE_LOCK, idx,
                     $urandom_range(3) == 0 ? $urandom : $urandom_range(7), $urandom);
      end else if (pick < 80) begin
        send_command(pilm_pkg::MODE_UNLOCK, idx,
                     (tbl_held[idx] && $urandom_range(3) != 0) ? tbl_owner[idx] : $urandom,
                     $urandom);
      end else begin
        send_command(pilm_pkg::MODE_QUERY, $urandom, $urandom_range(3) == 0 ? $urandom :
                     $urandom_range(7), $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    rsp_holdoff = 300;
    test_random(40);
    wait_drained();
  endtask

  initial begin
    int idle_wait;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    rsp_if.ready = 1'b0;
    n_errors = 0;
    idle_pct = 29;
    rsp_holdoff = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    wait_drained();
    idle_pct = 0;
    test_random(150);
    idle_pct = 29;
    test_backpressure();
    test_random(400);
    wait_drained();
    idle_wait = 0;
    while (idle_wait < 50) begin
      @(posedge clk_i);
      idle_wait++;
    end
    if (n_errors == 0 && rsp_expected_q.size() == 0) begin
      $display("[priority_inheritance_lock_manager_unit] OK");
    end else begin
      $display("[priority_inheritance_lock_manager_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[priority_inheritance_lock_manager_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
